FILE: rtl/lsqs_pkg.sv
// lsqs_pkg: word types and quantile constants of the labeled sample quantile store
package lsqs_pkg;

  typedef struct packed {
    logic        mode;
    logic [1:0]  label_index;
    logic [31:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic [39:0] p50_value;
    logic [39:0] p90_value;
    logic [39:0] p95_value;
    logic [39:0] p99_value;
    logic [31:0] min_value;
    logic [31:0] max_value;
    logic [31:0] sample_count;
    logic        samples_dropped;
  } out_word_t;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int NUM_QUANT = 4;
  localparam int QUANT_W   = 16;
  localparam int OUT_Q_W   = 40;

  localparam logic [QUANT_W-1:0] QUANT_Q16 [NUM_QUANT] = '{
    16'd32768, 16'd58982, 16'd62259, 16'd64881
  };

endpackage

FILE: rtl/labeled_sample_quantile_store_top.sv
// labeled_sample_quantile_store_top: per-label sorted sample store with quantile queries
//
// input channel (in_valid/in_ready/in_data) takes one word: mode add or query,
// a label and a sample. an add inserts the sample into the label's sorted
// region of one single-port-read memory by shifting larger entries up one
// place per cycle; an add to a full label only updates its total, min and
// max. adds to an unknown label are ignored, and adds make no result word.
// a query reads the two neighbors of each of the four quantile positions in
// the steps index, read a, read b, multiply and accumulate, and then loads one
// result word; an empty or unknown label skips the reads and gives an all-zero
// word. the memory read port yields one entry per cycle; one item is in work at a time.
// the result sits in an output register (out_valid/out_ready/out_data); a new
// item is accepted while it waits, and a query finishing while the receiver
// stalls holds until the register frees.
// synchronous reset clears counts, totals, max (min to all ones) of every label and
// the control state; the sample memory needs no clearing: only stored entries are read.
module labeled_sample_quantile_store_top
  import lsqs_pkg::*;
#(
  parameter int NUM_LABELS      = 4,
  parameter int SAMPLE_CAPACITY = 256,
  parameter int VALUE_BITS      = 32,
  parameter int FRAC_BITS       = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int LBW   = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
  localparam int PW    = $clog2(SAMPLE_CAPACITY);
  localparam int CW    = $clog2(SAMPLE_CAPACITY + 1);
  localparam int DEPTH = NUM_LABELS * SAMPLE_CAPACITY;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = QUANT_W + CW;
  localparam int MW    = VALUE_BITS + QUANT_W;
  localparam int QW    = VALUE_BITS + QUANT_W + 1;
  localparam int SH    = (FRAC_BITS < QUANT_W) ? (QUANT_W - FRAC_BITS) : 0;
  localparam int RSH   = (FRAC_BITS < QUANT_W) ? (QUANT_W - 1 - FRAC_BITS) : 0;
  localparam logic [QW-1:0] RND = (FRAC_BITS < QUANT_W) ? (QW'(1) << RSH) : '0;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_WR,
    S_Q_IDX, S_Q_RDA, S_Q_RDB, S_Q_MUL, S_Q_ACC, S_DONE
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         cnt_r   [NUM_LABELS];
  logic [31:0]           tot_r   [NUM_LABELS];
  logic [VALUE_BITS-1:0] min_r   [NUM_LABELS];
  logic [VALUE_BITS-1:0] max_r   [NUM_LABELS];
  logic [LBW-1:0]        label_r;
  logic [PW-1:0]         pos_r;
  logic [VALUE_BITS-1:0] v_r;
  logic [CW-1:0]         nm1_r;
  logic [1:0]            k_r;
  logic [PW-1:0]         lo_r;
  logic [PW-1:0]         hi_r;
  logic [QUANT_W-1:0]    frac_r;
  logic [VALUE_BITS-1:0] a_r;
  logic [MW-1:0]         mul_r;
  logic [OUT_Q_W-1:0]    qres_r  [NUM_QUANT];
  logic [31:0]           qmin_r;
  logic [31:0]           qmax_r;
  logic [31:0]           qtot_r;
  logic                  qdrop_r;
  logic                  out_valid_r;
  out_word_t             out_data_r;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;

  logic                  in_acc;
  logic                  lbl_ok;
  logic [LBW-1:0]        in_lbl;
  logic [VALUE_BITS-1:0] in_v;
  logic [IW-1:0]         idx;
  logic [CW-1:0]         lo_c;
  logic [CW-1:0]         hi_c;
  logic [QW-1:0]         q16;
  logic [QW-1:0]         qrnd;

  function automatic logic [AW-1:0] mem_addr(input logic [LBW-1:0] l,
                                             input logic [PW-1:0] p);
    return AW'(AW'(l) * AW'(SAMPLE_CAPACITY)) + AW'(p);
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign lbl_ok    = (32'(in_data.label_index) < NUM_LABELS);
  assign in_lbl    = LBW'(in_data.label_index);
  assign in_v      = VALUE_BITS'(in_data.sample_value);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idx  = IW'(QUANT_Q16[k_r]) * IW'(nm1_r);
  assign lo_c = CW'(idx >> QUANT_W);
  assign hi_c = ((lo_c + CW'(1)) > nm1_r) ? nm1_r : (lo_c + CW'(1));
  assign q16  = (QW'(a_r) << QUANT_W) + QW'(mul_r);
  assign qrnd = (q16 + RND) >> SH;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mem_addr(label_r, pos_r);
    mem_wdata = v_r;
    mem_raddr = mem_addr(label_r, pos_r - PW'(1));
    unique case (state_r)
      S_INS_CMP: begin
        if (rd_data_r > v_r) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data_r;
          mem_raddr = mem_addr(label_r, pos_r - PW'(2));
        end
      end
      S_INS_WR: begin
        mem_we = 1'b1;
      end
      S_Q_RDA: begin
        mem_raddr = mem_addr(label_r, lo_r);
      end
      S_Q_RDB: begin
        mem_raddr = mem_addr(label_r, hi_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LABELS; i++) begin
        cnt_r[i] <= '0;
        tot_r[i] <= '0;
        min_r[i] <= '1;
        max_r[i] <= '0;
      end
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            label_r <= in_lbl;
            v_r     <= in_v;
            k_r     <= '0;
            nm1_r   <= cnt_r[in_lbl] - CW'(1);
            pos_r   <= PW'(cnt_r[in_lbl]);
            qmin_r  <= 32'(min_r[in_lbl]);
            qmax_r  <= 32'(max_r[in_lbl]);
            qtot_r  <= tot_r[in_lbl];
            qdrop_r <= (tot_r[in_lbl] > 32'(cnt_r[in_lbl]));
            if (in_data.mode == MODE_ADD) begin
              if (lbl_ok) begin
                if (tot_r[in_lbl] != '1) begin
                  tot_r[in_lbl] <= tot_r[in_lbl] + 32'd1;
                end
                if (in_v < min_r[in_lbl]) begin
                  min_r[in_lbl] <= in_v;
                end
                if (in_v > max_r[in_lbl]) begin
                  max_r[in_lbl] <= in_v;
                end
                if (cnt_r[in_lbl] != CW'(SAMPLE_CAPACITY)) begin
                  cnt_r[in_lbl] <= cnt_r[in_lbl] + CW'(1);
                  state_r       <= S_INS_RD;
                end
              end
            end else begin
              if (!lbl_ok || cnt_r[in_lbl] == '0 || tot_r[in_lbl] == '0) begin
                for (int j = 0; j < NUM_QUANT; j++) begin
                  qres_r[j] <= '0;
                end
                qmin_r  <= '0;
                qmax_r  <= '0;
                qtot_r  <= '0;
                qdrop_r <= 1'b0;
                state_r <= S_DONE;
              end else begin
                state_r <= S_Q_IDX;
              end
            end
          end
        end
        S_INS_RD: begin
          state_r <= (pos_r == '0) ? S_INS_WR : S_INS_CMP;
        end
        S_INS_CMP: begin
          if (rd_data_r > v_r) begin
            pos_r <= pos_r - PW'(1);
            if (pos_r == PW'(1)) begin
              state_r <= S_INS_WR;
            end
          end else begin
            state_r <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          state_r <= S_IDLE;
        end
        S_Q_IDX: begin
          lo_r    <= PW'(lo_c);
          hi_r    <= PW'(hi_c);
          frac_r  <= idx[QUANT_W-1:0];
          state_r <= S_Q_RDA;
        end
        S_Q_RDA: begin
          state_r <= S_Q_RDB;
        end
        S_Q_RDB: begin
          a_r     <= rd_data_r;
          state_r <= S_Q_MUL;
        end
        S_Q_MUL: begin
          mul_r   <= MW'(rd_data_r - a_r) * MW'(frac_r);
          state_r <= S_Q_ACC;
        end
        S_Q_ACC: begin
          qres_r[k_r] <= OUT_Q_W'(qrnd);
          k_r         <= k_r + 2'd1;
          state_r     <= (k_r == 2'(NUM_QUANT - 1)) ? S_DONE : S_Q_IDX;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.p50_value       <= qres_r[0];
            out_data_r.p90_value       <= qres_r[1];
            out_data_r.p95_value       <= qres_r[2];
            out_data_r.p99_value       <= qres_r[3];
            out_data_r.min_value       <= qmin_r;
            out_data_r.max_value       <= qmax_r;
            out_data_r.sample_count    <= qtot_r;
            out_data_r.samples_dropped <= qdrop_r;
            state_r                    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/lsqs_checker.sv
// lsqs_checker: port-level assertions of the quantile store and their binding
module lsqs_checker
  import lsqs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_add_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode == MODE_ADD |=> !$rose(out_valid))
    else $error("add word produced a result");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while block was idle");

endmodule

bind labeled_sample_quantile_store_top lsqs_checker u_lsqs_checker (.*);
